### rtl/pawq_pkg.sv
// shared constants, status codes and bit helpers for the port allocator
package pawq_pkg;

	localparam int PORT_W  = 16;
	localparam int START_W = 15;
	localparam int IDX_W   = 15;
	localparam int ST_W    = 3;
	localparam int WORD_W  = 32;
	localparam int BIT_W   = 5;

	localparam logic [PORT_W-1:0] PORT_WILDCARD = '0;

	localparam logic K_RESERVE = 1'b0;
	localparam logic K_RETURN  = 1'b1;

	localparam logic [ST_W-1:0] ST_OK          = 3'd0;
	localparam logic [ST_W-1:0] ST_BAD_SERVICE = 3'd1;
	localparam logic [ST_W-1:0] ST_TAKEN       = 3'd2;
	localparam logic [ST_W-1:0] ST_OUT         = 3'd3;
	localparam logic [ST_W-1:0] ST_NOT_TAKEN   = 3'd4;

	// index of the lowest set bit, zero when none
	function automatic logic [BIT_W-1:0] first_set(input logic [WORD_W-1:0] v);
		logic [BIT_W-1:0] r;
		r = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = BIT_W'(i);
			end
		end
		return r;
	endfunction

	function automatic logic [WORD_W-1:0] bit_oh(input logic [BIT_W-1:0] b);
		return WORD_W'(1) << b;
	endfunction

	// bits at positions >= b
	function automatic logic [WORD_W-1:0] ge_mask(input logic [BIT_W-1:0] b);
		return ~((WORD_W'(1) << b) - WORD_W'(1));
	endfunction

	// bits at positions > b
	function automatic logic [WORD_W-1:0] gt_mask(input logic [BIT_W-1:0] b);
		return ~((WORD_W'(2) << b) - WORD_W'(1));
	endfunction

endpackage

### rtl/port_allocator_with_quarantine.sv
// port allocator with quarantine fifo of recently returned ephemeral ports
//
//  channel | signals                      | direction
//  --------+------------------------------+----------
//  request | in_valid in_stall            | in
//          | kind port rand_start         |
//  result  | out_valid out_stall          | out
//          | port_out status              |
//
// one request at a time; a new request is taken only once the last one has
// reached the result register; the read-modify-write passes over the bit
// memories set the path: reserve any needs up to three dependent reads, the
// fifo fallback adds the pop read and pop write states after the check, a
// quarantine overflow adds the fresh write state; a bad port skips the check
// after reset a clearing pass writes every bitmap word (NUM_PORTS/64 words
// per bitmap, 1024 at the defaults) while in_stall stays high
// a waiting result sits in the output register; the next request is taken,
// and its result is held back until the output register frees
module port_allocator_with_quarantine #(
	parameter int NUM_PORTS    = 65536,
	parameter int RECENT_DEPTH = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          kind,
	input  logic [pawq_pkg::PORT_W-1:0]   port,
	input  logic [pawq_pkg::START_W-1:0]  rand_start,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [pawq_pkg::PORT_W-1:0]   port_out,
	output logic [pawq_pkg::ST_W-1:0]     status
);
	import pawq_pkg::*;

	// NUM_PORTS is a power of two; index math relies on it
	localparam int N_EPH  = NUM_PORTS / 2;
	localparam int N_WORD = (N_EPH + WORD_W - 1) / WORD_W;
	localparam int WA     = (N_WORD > 1) ? $clog2(N_WORD) : 1;
	localparam int N_GRP  = (N_WORD + WORD_W - 1) / WORD_W;
	localparam int GA     = (N_GRP > 1) ? $clog2(N_GRP) : 1;
	localparam int FA     = (RECENT_DEPTH > 1) ? $clog2(RECENT_DEPTH) : 1;
	localparam int CW     = $clog2(RECENT_DEPTH + 1);

	// reset images: padding bits of short spaces stay zero
	localparam logic [WORD_W-1:0] WORD_INIT =
		(N_EPH >= WORD_W) ? {WORD_W{1'b1}} : WORD_W'((64'd1 << N_EPH) - 64'd1);
	localparam logic [WORD_W-1:0] SUM_INIT =
		(N_WORD >= WORD_W) ? {WORD_W{1'b1}} : WORD_W'((64'd1 << N_WORD) - 64'd1);
	localparam logic [WORD_W-1:0] L2_INIT =
		(N_GRP >= WORD_W) ? {WORD_W{1'b1}} : WORD_W'((64'd1 << N_GRP) - 64'd1);

	typedef enum logic [9:0] {
		S_CLEAR    = 10'b0000000001,
		S_IDLE     = 10'b0000000010,
		S_DECODE   = 10'b0000000100,
		S_CHECK    = 10'b0000001000,
		S_SRCH_L1  = 10'b0000010000,
		S_SRCH_W   = 10'b0000100000,
		S_POP_RD   = 10'b0001000000,
		S_POP_WR   = 10'b0010000000,
		S_FRESH_WR = 10'b0100000000,
		S_DONE     = 10'b1000000000
	} state_t;

	state_t state_q;

	// request registers
	logic                kind_q;
	logic [PORT_W-1:0]   port_q;
	logic [START_W-1:0]  start_q;

	// work registers
	logic [9:0]          word_q;   // chosen word in the ephemeral space
	logic [4:0]          grp_q;    // its summary group
	logic [BIT_W-1:0]    lo_q;     // lowest bit allowed in the chosen word
	logic [WORD_W-1:0]   sw_q;     // summary word of grp_q
	logic [IDX_W-1:0]    oidx_q;   // index of a port leaving the fifo
	logic [PORT_W-1:0]   res_q;
	logic [ST_W-1:0]     st_q;
	logic [FA-1:0]       head_q;
	logic [CW-1:0]       cnt_q;
	logic [WORD_W-1:0]   l2_q;     // one bit per summary word: any fresh port below
	logic [WA-1:0]       clr_q;

	logic                out_valid_q;
	logic [PORT_W-1:0]   port_out_q;
	logic [ST_W-1:0]     status_q;

	// memory ports
	logic                svc_we, ef_we, fr_we, sm_we, ff_we;
	logic [WA-1:0]       svc_waddr, ef_waddr, fr_waddr, svc_raddr, wd_raddr;
	logic [GA-1:0]       sm_waddr, sm_raddr;
	logic [FA-1:0]       ff_waddr, ff_raddr;
	logic [WORD_W-1:0]   svc_wdata, ef_wdata, fr_wdata, sm_wdata;
	logic [WORD_W-1:0]   svc_rdata, ef_rdata, fr_rdata, sm_rdata;
	logic [PORT_W-1:0]   ff_wdata, ff_rdata;

	// request decode
	logic                is_any, in_svc, in_eph;
	logic [IDX_W-1:0]    s0, eidx, oidx_c;
	logic                full;
	logic [FA-1:0]       tail, head_nx;
	logic [CW:0]         tsum;

	// search helpers
	logic [WORD_W-1:0]   m0, m1, m2;
	logic [9:0]          hit_word, l1_word;
	logic [4:0]          hit_grp;
	logic [BIT_W-1:0]    pick_b;
	logic [WORD_W-1:0]   pick_oh, new_fr, new_sm;
	logic                svc_bit, eph_bit;

	assign is_any = (kind_q == K_RESERVE) && (port_q == PORT_WILDCARD);
	assign in_svc = (port_q != PORT_WILDCARD) && ({1'b0, port_q} < 17'(N_EPH));
	assign in_eph = ({1'b0, port_q} >= 17'(N_EPH)) && ({1'b0, port_q} < 17'(NUM_PORTS));
	assign s0     = start_q & IDX_W'(N_EPH - 1);
	assign eidx   = IDX_W'(port_q - PORT_W'(N_EPH));
	assign oidx_c = IDX_W'(ff_rdata - PORT_W'(N_EPH));

	assign full    = (cnt_q == CW'(RECENT_DEPTH));
	assign tsum    = (CW + 1)'(head_q) + (CW + 1)'(cnt_q);
	assign tail    = (tsum >= (CW + 1)'(RECENT_DEPTH)) ?
		FA'(tsum - (CW + 1)'(RECENT_DEPTH)) : FA'(tsum);
	assign head_nx = (head_q == FA'(RECENT_DEPTH - 1)) ? '0 : head_q + FA'(1);

	assign svc_bit = svc_rdata[port_q[4:0]];
	assign eph_bit = ef_rdata[eidx[4:0]];

	// first level: bits of the start word, then later words of the start group,
	// then later groups, then wrap to the lowest fresh group
	always_comb begin
		m0       = fr_rdata & ge_mask(s0[4:0]);
		m1       = sm_rdata & gt_mask(s0[9:5]);
		m2       = l2_q & gt_mask(s0[14:10]);
		hit_word = (m0 != '0) ? s0[14:5] : {s0[14:10], first_set(m1)};
		hit_grp  = (m2 != '0) ? first_set(m2) : first_set(l2_q);
		l1_word  = {grp_q, first_set(sm_rdata)};
		pick_b   = first_set(fr_rdata & ge_mask(lo_q));
		pick_oh  = bit_oh(pick_b);
		new_fr   = fr_rdata & ~pick_oh;
		new_sm   = sw_q & ~bit_oh(word_q[4:0]);
	end

	// memory addressing and writes
	always_comb begin
		svc_raddr = port_q[WA+4:5];
		ff_raddr  = head_q;
		wd_raddr  = word_q[WA-1:0];
		sm_raddr  = grp_q[GA-1:0];

		svc_we    = 1'b0;
		svc_waddr = port_q[WA+4:5];
		svc_wdata = svc_rdata;
		ef_we     = 1'b0;
		ef_waddr  = word_q[WA-1:0];
		ef_wdata  = ef_rdata;
		fr_we     = 1'b0;
		fr_waddr  = word_q[WA-1:0];
		fr_wdata  = new_fr;
		sm_we     = 1'b0;
		sm_waddr  = grp_q[GA-1:0];
		sm_wdata  = new_sm;
		ff_we     = 1'b0;
		ff_waddr  = full ? head_q : tail;
		ff_wdata  = port_q;

		case (state_q)
			S_CLEAR: begin
				svc_we    = 1'b1;
				svc_waddr = clr_q;
				svc_wdata = {WORD_W{1'b1}};
				ef_we     = 1'b1;
				ef_waddr  = clr_q;
				ef_wdata  = WORD_INIT;
				fr_we     = 1'b1;
				fr_waddr  = clr_q;
				fr_wdata  = WORD_INIT;
				sm_we     = ({1'b0, clr_q} < (WA + 1)'(N_GRP));
				sm_waddr  = clr_q[GA-1:0];
				sm_wdata  = SUM_INIT;
			end
			S_DECODE: begin
				wd_raddr = is_any ? s0[WA+4:5] : eidx[WA+4:5];
				sm_raddr = s0[GA+9:10];
			end
			S_CHECK: begin
				if (is_any) begin
					wd_raddr = hit_word[WA-1:0];
					sm_raddr = hit_grp[GA-1:0];
				end else begin
					wd_raddr = oidx_c[WA+4:5];
					sm_raddr = oidx_c[GA+9:10];
				end
				if (kind_q == K_RESERVE) begin
					svc_we    = in_svc && svc_bit;
					svc_wdata = svc_rdata & ~bit_oh(port_q[4:0]);
				end else if (in_svc) begin
					svc_we    = !svc_bit;
					svc_wdata = svc_rdata | bit_oh(port_q[4:0]);
				end else begin
					ef_we    = !eph_bit;
					ef_waddr = eidx[WA+4:5];
					ef_wdata = ef_rdata | bit_oh(eidx[4:0]);
					ff_we    = !eph_bit;
				end
			end
			S_SRCH_L1: begin
				wd_raddr = l1_word[WA-1:0];
			end
			S_SRCH_W: begin
				fr_we    = 1'b1;
				ef_we    = 1'b1;
				ef_wdata = ef_rdata & ~pick_oh;
				sm_we    = (new_fr == '0);
			end
			S_POP_RD: begin
				wd_raddr = oidx_c[WA+4:5];
			end
			S_POP_WR: begin
				ef_we    = 1'b1;
				ef_waddr = oidx_q[WA+4:5];
				ef_wdata = ef_rdata & ~bit_oh(oidx_q[4:0]);
			end
			S_FRESH_WR: begin
				// quarantine over: port is fresh again
				fr_we    = 1'b1;
				fr_waddr = oidx_q[WA+4:5];
				fr_wdata = fr_rdata | bit_oh(oidx_q[4:0]);
				sm_we    = 1'b1;
				sm_waddr = oidx_q[GA+9:10];
				sm_wdata = sm_rdata | bit_oh(oidx_q[9:5]);
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			head_q      <= '0;
			cnt_q       <= '0;
			l2_q        <= L2_INIT;
			out_valid_q <= 1'b0;
		end else begin
			// a finishing request reloads the output register below
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + WA'(1);
					if (clr_q == WA'(N_WORD - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						kind_q  <= kind;
						port_q  <= port;
						start_q <= rand_start;
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					res_q <= PORT_WILDCARD;
					if (kind_q == K_RESERVE && !is_any && !in_svc) begin
						st_q    <= ST_BAD_SERVICE;
						state_q <= S_DONE;
					end else if (kind_q == K_RETURN && !in_svc && !in_eph) begin
						st_q    <= ST_NOT_TAKEN;
						state_q <= S_DONE;
					end else begin
						st_q    <= ST_OK;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (is_any) begin
						if (m0 != '0 || m1 != '0) begin
							word_q  <= hit_word;
							grp_q   <= s0[14:10];
							sw_q    <= sm_rdata;
							lo_q    <= (m0 != '0) ? s0[4:0] : '0;
							state_q <= S_SRCH_W;
						end else if (l2_q != '0) begin
							grp_q   <= hit_grp;
							lo_q    <= '0;
							state_q <= S_SRCH_L1;
						end else if (cnt_q != '0) begin
							// no fresh port: reuse the oldest quarantined one
							state_q <= S_POP_RD;
						end else begin
							st_q    <= ST_OUT;
							state_q <= S_DONE;
						end
					end else if (kind_q == K_RESERVE) begin
						state_q <= S_DONE;
						if (svc_bit) begin
							res_q <= port_q;
						end else begin
							st_q <= ST_TAKEN;
						end
					end else if (in_svc) begin
						state_q <= S_DONE;
						if (svc_bit) begin
							st_q <= ST_NOT_TAKEN;
						end
					end else begin
						if (eph_bit) begin
							st_q    <= ST_NOT_TAKEN;
							state_q <= S_DONE;
						end else if (!full) begin
							cnt_q   <= cnt_q + CW'(1);
							state_q <= S_DONE;
						end else begin
							// overwrite the oldest entry, release it from quarantine
							head_q  <= head_nx;
							oidx_q  <= oidx_c;
							state_q <= S_FRESH_WR;
						end
					end
				end
				S_SRCH_L1: begin
					word_q  <= l1_word;
					sw_q    <= sm_rdata;
					state_q <= S_SRCH_W;
				end
				S_SRCH_W: begin
					res_q <= PORT_W'(N_EPH) + PORT_W'({word_q, pick_b});
					if (new_fr == '0 && new_sm == '0) begin
						l2_q[grp_q] <= 1'b0;
					end
					state_q <= S_DONE;
				end
				S_POP_RD: begin
					res_q   <= ff_rdata;
					oidx_q  <= oidx_c;
					state_q <= S_POP_WR;
				end
				S_POP_WR: begin
					head_q  <= head_nx;
					cnt_q   <= cnt_q - CW'(1);
					state_q <= S_DONE;
				end
				S_FRESH_WR: begin
					l2_q[oidx_q[14:10]] <= 1'b1;
					state_q             <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!out_valid_q || !out_stall)) begin
			port_out_q <= res_q;
			status_q   <= st_q;
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign port_out  = port_out_q;
	assign status    = status_q;

	// service ports free, by port number
	pawq_ram #(.W(WORD_W), .D(N_WORD)) u_svc (
		.clk   (clk),
		.we    (svc_we),
		.waddr (svc_waddr),
		.wdata (svc_wdata),
		.raddr (svc_raddr),
		.rdata (svc_rdata)
	);

	// ephemeral free bits
	pawq_ram #(.W(WORD_W), .D(N_WORD)) u_efree (
		.clk   (clk),
		.we    (ef_we),
		.waddr (ef_waddr),
		.wdata (ef_wdata),
		.raddr (wd_raddr),
		.rdata (ef_rdata)
	);

	// ephemeral fresh bits
	pawq_ram #(.W(WORD_W), .D(N_WORD)) u_fresh (
		.clk   (clk),
		.we    (fr_we),
		.waddr (fr_waddr),
		.wdata (fr_wdata),
		.raddr (wd_raddr),
		.rdata (fr_rdata)
	);

	// one bit per fresh word: word holds any fresh port
	pawq_ram #(.W(WORD_W), .D(N_GRP)) u_sum (
		.clk   (clk),
		.we    (sm_we),
		.waddr (sm_waddr),
		.wdata (sm_wdata),
		.raddr (sm_raddr),
		.rdata (sm_rdata)
	);

	// quarantine fifo of returned ephemeral ports
	pawq_ram #(.W(PORT_W), .D(RECENT_DEPTH)) u_fifo (
		.clk   (clk),
		.we    (ff_we),
		.waddr (ff_waddr),
		.wdata (ff_wdata),
		.raddr (ff_raddr),
		.rdata (ff_rdata)
	);

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(RECENT_DEPTH))
		else $error("quarantine count above depth");

	a_l2_pad: assert property (@(posedge clk) disable iff (!arst_n)
		(l2_q & ~L2_INIT) == '0)
		else $error("summary bit set for a group that does not exist");

	a_clear_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> in_stall)
		else $error("request taken during clearing pass");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result shown without finishing a request");

endmodule

### rtl/pawq_ram.sv
// generic simple dual port ram with registered read
module pawq_ram #(
	parameter int W = 32,
	parameter int D = 1024
) (
	input  logic                                clk,
	input  logic                                we,
	input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
	input  logic [W-1:0]                        wdata,
	input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
	output logic [W-1:0]                        rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
